// ----- src/fc_pkg.sv -----
// fc_pkg: shared widths, register indexes and types for the foreground centroid block
// used by the top level, the shared divider and the port checker
`timescale 1ns / 1ps
`default_nettype none

package fc_pkg;

    localparam int POS_W     = 9;
    localparam int SUM_W     = 27;
    localparam int CNT_W     = 19;
    localparam int DEPTH_W   = 8;
    localparam int CFG_DIM_W = 10;
    localparam int CFG_THR_W = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FG_THRESHOLD = 2'd2;

    localparam logic [CFG_DIM_W-1:0] RST_FRAME_WIDTH  = 10'd512;
    localparam logic [CFG_DIM_W-1:0] RST_FRAME_HEIGHT = 10'd424;
    localparam logic [CFG_THR_W-1:0] RST_FG_THRESHOLD = 8'd1;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quo;
    } t_div_stat;

endpackage

`default_nettype wire

// ----- src/fc_div.sv -----
// fc_div: restoring divider, one quotient bit per cycle, shared for both centroid axes
// depends on fc_pkg for widths and the status struct
`timescale 1ns / 1ps
`default_nettype none

module fc_div import fc_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [SUM_W-1:0] i_dividend,
    input  wire logic [CNT_W-1:0] i_divisor,
    output t_div_stat             o_stat
);

    localparam int IT_W = $clog2(SUM_W);
    localparam logic [IT_W-1:0] LAST_IT = IT_W'(SUM_W - 1);

    logic            r_busy;
    logic            r_done;
    logic [IT_W-1:0] r_cnt;
    logic [SUM_W-1:0] r_quo;
    logic [CNT_W-1:0] r_rem;
    logic [CNT_W-1:0] r_dvs;

    logic [CNT_W:0] rem_sh;
    logic [CNT_W:0] diff;
    logic           ge;

    always_comb begin
        rem_sh = {r_rem, r_quo[SUM_W-1]};
        ge     = rem_sh >= {1'b0, r_dvs};
        diff   = rem_sh - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == LAST_IT) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            r_quo <= {r_quo[SUM_W-2:0], ge};
        end
    end

    assign o_stat = {r_done, r_quo};

endmodule

`default_nettype wire

// ----- src/foreground_centroid.sv -----
// foreground_centroid: per-pixel foreground mask with frame-level first-moment centroid
// depends on fc_pkg and the shared divider fc_div
//
//  channel | direction | handshake                 | payload
//  in      | input     | i_in_valid / o_in_ready   | i_depth_value, i_frame_start
//  out     | output    | o_out_valid / i_out_ready | pixel position, mask, frame result
//  cfg     | input     | i_cfg_we                  | i_cfg_addr, i_cfg_wdata
//
// a pixel that does not end its frame goes straight to the output register
// the last pixel of a frame with foreground goes through the one shared 27-step divider, which
// runs for the column sum and then the row sum, and no item is accepted meanwhile
// the last pixel of a frame with no foreground skips the divider and goes to ST_FIN
// a waiting result in the output register blocks input only while it is not being taken
// reset is synchronous, active low, and restores the default frame size and threshold
`timescale 1ns / 1ps
`default_nettype none

module foreground_centroid import fc_pkg::*; #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DIM_W-1:0] i_cfg_wdata,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [DEPTH_W-1:0]   i_depth_value,
    input  wire logic                 i_frame_start,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [POS_W-1:0]          o_pixel_col,
    output logic [POS_W-1:0]          o_pixel_row,
    output logic                      o_is_foreground,
    output logic                      o_frame_done,
    output logic                      o_centroid_valid,
    output logic [POS_W-1:0]          o_centroid_col,
    output logic [POS_W-1:0]          o_centroid_row,
    output logic [CNT_W-1:0]          o_foreground_total
);

    localparam int CFG_MAX = (1 << CFG_DIM_W) - 1;
    localparam logic [CFG_DIM_W-1:0] W_LIM =
        CFG_DIM_W'((MAX_WIDTH > CFG_MAX) ? CFG_MAX : MAX_WIDTH);
    localparam logic [CFG_DIM_W-1:0] H_LIM =
        CFG_DIM_W'((MAX_HEIGHT > CFG_MAX) ? CFG_MAX : MAX_HEIGHT);

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_DIV_COL = 4'b0010,
        ST_DIV_ROW = 4'b0100,
        ST_FIN     = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [CFG_DIM_W-1:0] r_frame_w;
    logic [CFG_DIM_W-1:0] r_frame_h;
    logic [CFG_THR_W-1:0] r_thr;

    logic [POS_W-1:0] r_col_pos, n_col_pos;
    logic [POS_W-1:0] r_row_pos, n_row_pos;
    logic [SUM_W-1:0] r_col_sum, n_col_sum;
    logic [SUM_W-1:0] r_row_sum, n_row_sum;
    logic [CNT_W-1:0] r_fg_cnt,  n_fg_cnt;

    // final pixel result waiting for the divider
    logic [POS_W-1:0] r_pend_col;
    logic [POS_W-1:0] r_pend_row;
    logic             r_pend_fg;
    logic [CNT_W-1:0] r_pend_cnt;
    logic [SUM_W-1:0] r_pend_row_sum;
    logic [POS_W-1:0] r_cent_col;
    logic [POS_W-1:0] r_cent_row;

    logic             r_out_valid;
    logic [POS_W-1:0] r_out_col;
    logic [POS_W-1:0] r_out_row;
    logic             r_out_fg;
    logic             r_out_done;
    logic             r_out_cvalid;
    logic [POS_W-1:0] r_out_ccol;
    logic [POS_W-1:0] r_out_crow;
    logic [CNT_W-1:0] r_out_total;

    logic [CFG_DIM_W-1:0] w_eff, h_eff, w_m1, h_m1;
    logic [POS_W-1:0]     cp, rp;
    logic [SUM_W-1:0]     base_col_sum, base_row_sum;
    logic [CNT_W-1:0]     base_cnt;
    logic                 fg, last_row, last_col, done;
    logic                 accept, out_free;

    logic             div_start;
    logic [SUM_W-1:0] div_dividend;
    logic [CNT_W-1:0] div_divisor;
    t_div_stat        div_stat;

    always_comb begin
        w_eff = (r_frame_w == '0) ? CFG_DIM_W'(1) :
                ((r_frame_w > W_LIM) ? W_LIM : r_frame_w);
        h_eff = (r_frame_h == '0) ? CFG_DIM_W'(1) :
                ((r_frame_h > H_LIM) ? H_LIM : r_frame_h);
        w_m1  = w_eff - 1'b1;
        h_m1  = h_eff - 1'b1;
    end

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && out_free;
    assign accept     = i_in_valid && o_in_ready;

    // frame start clears position and sums before this pixel counts
    always_comb begin
        cp           = i_frame_start ? '0 : r_col_pos;
        rp           = i_frame_start ? '0 : r_row_pos;
        base_col_sum = i_frame_start ? '0 : r_col_sum;
        base_row_sum = i_frame_start ? '0 : r_row_sum;
        base_cnt     = i_frame_start ? '0 : r_fg_cnt;
        fg           = i_depth_value >= r_thr;
        n_col_sum    = base_col_sum + (fg ? SUM_W'(cp) : '0);
        n_row_sum    = base_row_sum + (fg ? SUM_W'(rp) : '0);
        n_fg_cnt     = base_cnt + CNT_W'(fg);
        last_row     = {1'b0, rp} >= h_m1;
        last_col     = {1'b0, cp} >= w_m1;
        done         = last_row && last_col;
        n_col_pos    = cp;
        n_row_pos    = rp + 1'b1;
        if (last_row) begin
            n_row_pos = '0;
            n_col_pos = cp + 1'b1;
        end
    end

    always_comb begin
        div_start    = 1'b0;
        div_dividend = r_pend_row_sum;
        div_divisor  = r_pend_cnt;
        if (r_state == ST_IDLE) begin
            div_dividend = n_col_sum;
            div_divisor  = n_fg_cnt;
            div_start    = accept && done && (n_fg_cnt != '0);
        end else if (r_state == ST_DIV_COL) begin
            div_start = div_stat.done;
        end
    end

    fc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_stat     (div_stat)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && done) begin
                    n_state = (n_fg_cnt != '0) ? ST_DIV_COL : ST_FIN;
                end
            end
            ST_DIV_COL: begin
                if (div_stat.done) begin
                    n_state = ST_DIV_ROW;
                end
            end
            ST_DIV_ROW: begin
                if (div_stat.done) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_frame_w <= RST_FRAME_WIDTH;
            r_frame_h <= RST_FRAME_HEIGHT;
            r_thr     <= RST_FG_THRESHOLD;
            r_col_pos <= '0;
            r_row_pos <= '0;
            r_col_sum <= '0;
            r_row_sum <= '0;
            r_fg_cnt  <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_FRAME_WIDTH:  r_frame_w <= i_cfg_wdata;
                    REG_FRAME_HEIGHT: r_frame_h <= i_cfg_wdata;
                    REG_FG_THRESHOLD: r_thr     <= i_cfg_wdata[CFG_THR_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                if (done) begin
                    r_col_pos <= '0;
                    r_row_pos <= '0;
                    r_col_sum <= '0;
                    r_row_sum <= '0;
                    r_fg_cnt  <= '0;
                end else begin
                    r_col_pos <= n_col_pos;
                    r_row_pos <= n_row_pos;
                    r_col_sum <= n_col_sum;
                    r_row_sum <= n_row_sum;
                    r_fg_cnt  <= n_fg_cnt;
                end
            end
        end
    end

    // pending frame result and centroid quotients
    always_ff @(posedge i_clk) begin
        if (accept && done) begin
            r_pend_col     <= cp;
            r_pend_row     <= rp;
            r_pend_fg      <= fg;
            r_pend_cnt     <= n_fg_cnt;
            r_pend_row_sum <= n_row_sum;
            r_cent_col     <= '0;
            r_cent_row     <= '0;
        end
        if (r_state == ST_DIV_COL && div_stat.done) begin
            r_cent_col <= div_stat.quo[POS_W-1:0];
        end
        if (r_state == ST_DIV_ROW && div_stat.done) begin
            r_cent_row <= div_stat.quo[POS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && !done) begin
            r_out_valid <= 1'b1;
        end else if (r_state == ST_FIN && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !done) begin
            r_out_col    <= cp;
            r_out_row    <= rp;
            r_out_fg     <= fg;
            r_out_done   <= 1'b0;
            r_out_cvalid <= 1'b0;
            r_out_ccol   <= '0;
            r_out_crow   <= '0;
            r_out_total  <= '0;
        end else if (r_state == ST_FIN && out_free) begin
            r_out_col    <= r_pend_col;
            r_out_row    <= r_pend_row;
            r_out_fg     <= r_pend_fg;
            r_out_done   <= 1'b1;
            r_out_cvalid <= r_pend_cnt != '0;
            r_out_ccol   <= r_cent_col;
            r_out_crow   <= r_cent_row;
            r_out_total  <= r_pend_cnt;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_pixel_col        = r_out_col;
    assign o_pixel_row        = r_out_row;
    assign o_is_foreground    = r_out_fg;
    assign o_frame_done       = r_out_done;
    assign o_centroid_valid   = r_out_cvalid;
    assign o_centroid_col     = r_out_ccol;
    assign o_centroid_row     = r_out_crow;
    assign o_foreground_total = r_out_total;

endmodule

`default_nettype wire

// ----- src/fc_checker.sv -----
// fc_checker: port-level checks on the foreground centroid top level
// depends on fc_pkg for widths; bound to foreground_centroid below
`timescale 1ns / 1ps
`default_nettype none

module fc_checker import fc_pkg::*; (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             o_out_valid,
    input wire logic             i_out_ready,
    input wire logic [POS_W-1:0] o_pixel_col,
    input wire logic [POS_W-1:0] o_pixel_row,
    input wire logic             o_is_foreground,
    input wire logic             o_frame_done,
    input wire logic             o_centroid_valid,
    input wire logic [POS_W-1:0] o_centroid_col,
    input wire logic [POS_W-1:0] o_centroid_row,
    input wire logic [CNT_W-1:0] o_foreground_total
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pixel_col)
            && $stable(o_pixel_row) && $stable(o_is_foreground)
            && $stable(o_frame_done) && $stable(o_foreground_total))
        else $error("output item changed while stalled");

    // no result right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // centroid flagged only on a nonempty frame end
    a_cvalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_centroid_valid |-> o_frame_done && o_foreground_total != '0)
        else $error("centroid valid without frame end or foreground");

    // mid-frame items carry no frame result
    a_mid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_frame_done |-> !o_centroid_valid && o_centroid_col == '0
            && o_centroid_row == '0 && o_foreground_total == '0)
        else $error("frame result on a mid-frame item");

endmodule

bind foreground_centroid fc_checker u_fc_checker (.*);

`default_nettype wire

// ----- bench/foreground_centroid_test.sv -----
// foreground_centroid_test: self-checking bench for the foreground centroid block
// directed table then random frames under several idle patterns; needs fc_pkg and the rtl
`timescale 1ns / 1ps

module foreground_centroid_test;
    import fc_pkg::*;

    localparam int MAX_WIDTH   = 512;
    localparam int MAX_HEIGHT  = 512;
    localparam int STALL_LIMIT = 4000;
    localparam int PRINT_LIMIT = 200;

    typedef struct packed {
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             fg;
        logic             done;
        logic             valid;
        logic [POS_W-1:0] cen_col;
        logic [POS_W-1:0] cen_row;
        logic [CNT_W-1:0] total;
    } t_pixel_result;

    typedef enum logic {STEP_PIXEL, STEP_WRITE} t_step_kind;

    typedef struct {
        t_step_kind           kind;
        logic [CFG_IDX_W-1:0] addr;
        logic [CFG_DIM_W-1:0] data;
        logic [DEPTH_W-1:0]   depth;
        logic                 start;
        logic                 typed;
        t_pixel_result        want;
    } t_step_row;

    localparam t_pixel_result UNTYPED = '0;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_addr    = '0;
    logic [CFG_DIM_W-1:0] i_cfg_wdata   = '0;
    logic                 i_in_valid    = 1'b0;
    logic [DEPTH_W-1:0]   i_depth_value = '0;
    logic                 i_frame_start = 1'b0;
    logic                 i_out_ready   = 1'b0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [POS_W-1:0]     o_pixel_col;
    logic [POS_W-1:0]     o_pixel_row;
    logic                 o_is_foreground;
    logic                 o_frame_done;
    logic                 o_centroid_valid;
    logic [POS_W-1:0]     o_centroid_col;
    logic [POS_W-1:0]     o_centroid_row;
    logic [CNT_W-1:0]     o_foreground_total;

    foreground_centroid #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_depth_value     (i_depth_value),
        .i_frame_start     (i_frame_start),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_pixel_col       (o_pixel_col),
        .o_pixel_row       (o_pixel_row),
        .o_is_foreground   (o_is_foreground),
        .o_frame_done      (o_frame_done),
        .o_centroid_valid  (o_centroid_valid),
        .o_centroid_col    (o_centroid_col),
        .o_centroid_row    (o_centroid_row),
        .o_foreground_total(o_foreground_total)
    );

    always #4 i_clk = ~i_clk;

    // predictor state
    logic [CFG_DIM_W-1:0] set_width     = RST_FRAME_WIDTH;
    logic [CFG_DIM_W-1:0] set_height    = RST_FRAME_HEIGHT;
    logic [CFG_THR_W-1:0] set_threshold = RST_FG_THRESHOLD;
    logic [POS_W-1:0]     cur_col       = '0;
    logic [POS_W-1:0]     cur_row       = '0;
    logic [SUM_W-1:0]     col_moment    = '0;
    logic [SUM_W-1:0]     row_moment    = '0;
    logic [CNT_W-1:0]     fg_pixels     = '0;

    t_pixel_result pending_pixels[$];
    int unsigned   mismatches  = 0;
    int unsigned   quiet_cycles = 0;
    int unsigned   idle_pct    = 0;
    int unsigned   stall_pct   = 0;

    t_step_row directed_steps [26] = '{
        // pixel rows typed as col, row, fg, done, valid, cen_col, cen_row, total
        '{STEP_PIXEL, REG_FRAME_WIDTH, 10'd0, 8'd0, 1'b0, 1'b1,
          '{9'd0, 9'd0, 1'b0, 1'b0, 1'b0, 9'd0, 9'd0, 19'd0}},
        '{STEP_PIXEL, REG_FRAME_WIDTH, 10'd0, 8'd255, 1'b0, 1'b1,
          '{9'd0, 9'd1, 1'b1, 1'b0, 1'b0, 9'd0, 9'd0, 19'd0}},
        '{STEP_PIXEL, REG_FRAME_WIDTH, 10'd0, 8'd1, 1'b1, 1'b1,
          '{9'd0, 9'd0, 1'b1, 1'b0, 1'b0, 9'd0, 9'd0, 19'd0}},
        '{STEP_WRITE, REG_FRAME_WIDTH, 10'd1, 8'd0, 1'b0, 1'b0, UNTYPED},
        '{STEP_WRITE, REG_FRAME_HEIGHT, 10'd1, 8'd0, 1'b0, 1'b0, UNTYPED},
        // shrunk mid-frame: wraps at once
        '{STEP_PIXEL, REG_FRAME_WIDTH, 10'd0, 8'd0, 1'b0, 1'b1,
          '{9'd0, 9'd1, 1'b0, 1'b1, 1'b1, 9'd0, 9'd0, 19'd1}},
        // empty frame
        '{STEP_PIXEL, REG_FRAME_WIDTH, 10'd0, 8'd0, 1'b0, 1'b1,
          '{9'd0, 9'd0, 1'b0, 1'b1, 1'b0, 9'd0, 9'd0, 19'd0}},
        '{STEP_PIXEL, REG_FRAME_WIDTH, 10'd0, 8'd255, 1'b0, 1'b1,
          '{9'd0, 9'd0, 1'b1, 1'b1, 1'b1, 9'd0, 9'd0, 19'd1}},
        '{STEP_WRITE, REG_FG_THRESHOLD, 10'd0, 8'd0, 1'b0, 1'b0, UNTYPED},
        '{STEP_PIXEL, REG_FRAME_WIDTH, 10'd0, 8'd0, 1'b0, 1'b1,
          '{9'd0, 9'd0, 1'b1, 1'b1, 1'b1, 9'd0, 9'd0, 19'd1}},
        '{STEP_WRITE, REG_FRAME_WIDTH, 10'd0, 8'd0, 1'b0, 1'b0, UNTYPED},
        '{STEP_WRITE, REG_FRAME_HEIGHT, 10'd0, 8'd0, 1'b0, 1'b0, UNTYPED},
        '{STEP_PIXEL, REG_FRAME_WIDTH, 10'd0, 8'd128, 1'b1, 1'b1,
          '{9'd0, 9'd0, 1'b1, 1'b1, 1'b1, 9'd0, 9'd0, 19'd1}},
        '{STEP_WRITE, REG_FRAME_WIDTH, 10'd3, 8'd0, 1'b0, 1'b0, UNTYPED},
        '{STEP_WRITE, REG_FRAME_HEIGHT, 10'd2, 8'd0, 1'b0, 1'b0, UNTYPED},
        '{STEP_WRITE, REG_FG_THRESHOLD, 10'd255, 8'd0, 1'b0, 1'b0, UNTYPED},
        '{STEP_PIXEL, REG_FRAME_WIDTH, 10'd0, 8'd255, 1'b1, 1'b0, UNTYPED},
        '{STEP_PIXEL, REG_FRAME_WIDTH, 10'd0, 8'd0, 1'b0, 1'b0, UNTYPED},
        '{STEP_PIXEL, REG_FRAME_WIDTH, 10'd0, 8'd255, 1'b0, 1'b0, UNTYPED},
        '{STEP_PIXEL, REG_FRAME_WIDTH, 10'd0, 8'd254, 1'b0, 1'b0, UNTYPED},
        '{STEP_PIXEL, REG_FRAME_WIDTH, 10'd0, 8'd0, 1'b0, 1'b0, UNTYPED},
        '{STEP_PIXEL, REG_FRAME_WIDTH, 10'd0, 8'd255, 1'b0, 1'b0, UNTYPED},
        // oversize settings clamp to the maximum
        '{STEP_WRITE, REG_FRAME_WIDTH, 10'd1023, 8'd0, 1'b0, 1'b0, UNTYPED},
        '{STEP_WRITE, REG_FRAME_HEIGHT, 10'd600, 8'd0, 1'b0, 1'b0, UNTYPED},
        '{STEP_PIXEL, REG_FRAME_WIDTH, 10'd0, 8'd255, 1'b1, 1'b1,
          '{9'd0, 9'd0, 1'b1, 1'b0, 1'b0, 9'd0, 9'd0, 19'd0}},
        '{STEP_PIXEL, REG_FRAME_WIDTH, 10'd0, 8'd254, 1'b0, 1'b1,
          '{9'd0, 9'd1, 1'b0, 1'b0, 1'b0, 9'd0, 9'd0, 19'd0}}
    };

    function automatic int unsigned frame_extent(input logic [CFG_DIM_W-1:0] setting,
                                                 input int unsigned limit);
        if (setting == 0)
            return 1;
        if (setting > limit)
            return limit;
        return 32'(setting);
    endfunction

    function automatic void clear_moments();
        cur_col    = '0;
        cur_row    = '0;
        col_moment = '0;
        row_moment = '0;
        fg_pixels  = '0;
    endfunction

    function automatic t_pixel_result classify_pixel(input logic [DEPTH_W-1:0] depth,
                                                     input logic start);
        int unsigned   cols;
        int unsigned   rows;
        logic          last_row;
        logic          last_col;
        t_pixel_result r;
        cols = frame_extent(set_width, MAX_WIDTH);
        rows = frame_extent(set_height, MAX_HEIGHT);
        r = '0;
        if (start)
            clear_moments();
        r.fg = depth >= set_threshold;
        if (r.fg) begin
            col_moment = col_moment + SUM_W'(cur_col);
            row_moment = row_moment + SUM_W'(cur_row);
            fg_pixels  = fg_pixels + 1'b1;
        end
        last_row = cur_row >= rows - 1;
        last_col = cur_col >= cols - 1;
        r.col  = cur_col;
        r.row  = cur_row;
        r.done = last_row && last_col;
        if (r.done) begin
            r.total = fg_pixels;
            if (fg_pixels != 0) begin
                r.valid   = 1'b1;
                r.cen_col = POS_W'(col_moment / fg_pixels);
                r.cen_row = POS_W'(row_moment / fg_pixels);
            end
            clear_moments();
        end else if (last_row) begin
            cur_row = '0;
            cur_col = cur_col + 1'b1;
        end else begin
            cur_row = cur_row + 1'b1;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task automatic check_result(input t_pixel_result got, input t_pixel_result want);
        if (got.col != want.col)
            report_mismatch($sformatf("pixel_col %0d want %0d", got.col, want.col));
        if (got.row != want.row)
            report_mismatch($sformatf("pixel_row %0d want %0d", got.row, want.row));
        if (got.fg != want.fg)
            report_mismatch($sformatf("is_foreground %0d want %0d", got.fg, want.fg));
        if (got.done != want.done)
            report_mismatch($sformatf("frame_done %0d want %0d", got.done, want.done));
        if (got.valid != want.valid)
            report_mismatch($sformatf("centroid_valid %0d want %0d", got.valid, want.valid));
        if (got.cen_col != want.cen_col)
            report_mismatch($sformatf("centroid_col %0d want %0d", got.cen_col, want.cen_col));
        if (got.cen_row != want.cen_row)
            report_mismatch($sformatf("centroid_row %0d want %0d", got.cen_row, want.cen_row));
        if (got.total != want.total)
            report_mismatch($sformatf("foreground_total %0d want %0d", got.total, want.total));
    endtask

    // hold the sender until every result has been taken
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_pixels.size() != 0);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] addr,
                                  input logic [CFG_DIM_W-1:0] data);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (addr)
            REG_FRAME_WIDTH:  set_width = data;
            REG_FRAME_HEIGHT: set_height = data;
            REG_FG_THRESHOLD: set_threshold = data[CFG_THR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_pixel(input logic [DEPTH_W-1:0] depth, input logic start,
                              input logic typed, input t_pixel_result want);
        t_pixel_result predicted;
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_depth_value <= depth;
        i_frame_start <= start;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = classify_pixel(depth, start);
        pending_pixels.push_back(typed ? want : predicted);
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= $urandom_range(0, 99) >= stall_pct;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_pixels.size() == 0)
                report_mismatch("item with nothing expected");
            else
                check_result({o_pixel_col, o_pixel_row, o_is_foreground, o_frame_done,
                              o_centroid_valid, o_centroid_col, o_centroid_row,
                              o_foreground_total}, pending_pixels.pop_front());
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int unsigned          items;
        logic                 wide;
        logic                 start;
        logic [DEPTH_W-1:0]   depth;
        logic [CFG_DIM_W-1:0] width_set;
        logic [CFG_DIM_W-1:0] height_set;
        logic [CFG_THR_W-1:0] thr_set;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_steps[i]) begin
            if (directed_steps[i].kind == STEP_WRITE)
                write_register(directed_steps[i].addr, directed_steps[i].data);
            else
                send_pixel(directed_steps[i].depth, directed_steps[i].start,
                           directed_steps[i].typed, directed_steps[i].want);
        end

        for (int p = 0; p < 8; p++) begin
            wide = (p == 2) || (p == 5);
            case (p % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 78; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 78; end
                default: begin idle_pct = 6;  stall_pct = 6;  end
            endcase
            case (p)
                2: begin
                    width_set  = CFG_DIM_W'($urandom_range(512, 1023));
                    height_set = 10'd1;
                end
                5: begin
                    width_set  = 10'd1;
                    height_set = CFG_DIM_W'($urandom_range(512, 1023));
                end
                6: begin
                    width_set  = CFG_DIM_W'($urandom_range(9, 24));
                    height_set = CFG_DIM_W'($urandom_range(9, 24));
                end
                7: begin
                    width_set  = CFG_DIM_W'($urandom_range(0, 3));
                    height_set = CFG_DIM_W'($urandom_range(0, 3));
                end
                default: begin
                    width_set  = CFG_DIM_W'($urandom_range(1, 8));
                    height_set = CFG_DIM_W'($urandom_range(1, 8));
                end
            endcase
            if (p == 0)
                thr_set = 8'd0;
            else if (p == 3)
                thr_set = 8'd255;
            else if (wide)
                thr_set = CFG_THR_W'($urandom_range(1, 255));
            else
                thr_set = CFG_THR_W'($urandom_range(0, 255));
            write_register(REG_FRAME_WIDTH, width_set);
            write_register(REG_FRAME_HEIGHT, height_set);
            write_register(REG_FG_THRESHOLD, {2'b00, thr_set});

            items = wide ? 540 : 150;
            for (int k = 0; k < items; k++) begin
                if (k == items / 2)
                    drain_results();
                start = (k == 0) ||
                        (cur_col == 0 && cur_row == 0 && $urandom_range(0, 1) == 1) ||
                        (!wide && $urandom_range(0, 99) < 3);
                if (wide) begin
                    // far end lights up: p 2 centroid at the edge; p 5 adds random pixels
                    if (int'(cur_col) + int'(cur_row) >= 511)
                        depth = 8'd255;
                    else if (p == 5 && $urandom_range(0, 99) < 3)
                        depth = DEPTH_W'($urandom_range(0, 255));
                    else
                        depth = 8'd0;
                end else begin
                    case ($urandom_range(0, 3))
                        0, 1:    depth = DEPTH_W'($urandom_range(0, 255));
                        2:       depth = set_threshold;
                        default: depth = set_threshold - 1'b1;
                    endcase
                end
                send_pixel(depth, start, 1'b0, UNTYPED);
            end
        end

        drain_results();
        repeat (100) @(posedge i_clk);
        if (pending_pixels.size() != 0)
            report_mismatch("results never arrived");
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- foreground_centroid.f -----
src/fc_pkg.sv
src/fc_div.sv
src/foreground_centroid.sv
src/fc_checker.sv
bench/foreground_centroid_test.sv
